/* rtl/mtd_pkg.sv */
// Shared types and constants for the motor telemetry decoder.
// No dependencies; imported by every module of the block.
package mtd_pkg;

  localparam int MOTOR_W    = 3;
  localparam int FRAME_W    = 12;
  localparam int VALUE_W    = 20;
  localparam int KIND_W     = 3;
  localparam int KIND_COUNT = 8;
  localparam int TEMP_W     = 8;
  localparam int MANT_W     = 9;
  localparam int PERIOD_W   = 16;
  localparam int DIV_STEPS  = VALUE_W;
  localparam int CNT_W      = 5;

  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 4;

  localparam logic [KIND_W-1:0]  KIND_ERPM  = 3'd0;
  localparam logic [KIND_W-1:0]  KIND_TEMP  = 3'd1;
  localparam logic [KIND_W-1:0]  KIND_STATE = 3'd7;

  localparam logic [FRAME_W-1:0] FRAME_ZERO_RPM     = 12'hFFF;
  localparam logic [FRAME_W-1:0] FRAME_STATE_ENABLE = 12'hE00;
  localparam logic [VALUE_W-1:0] ERPM_NUMERATOR     = 20'd600000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_DIVIDE,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic div_step;
    logic commit;
  } mtd_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } mtd_sts_t;

endpackage

/* rtl/mtd_ctrl.sv */
// Sequencer for the motor telemetry decoder: accept, decode, divide, write.
// Depends on mtd_pkg; drives the command struct of mtd_datapath.
module mtd_ctrl
  import mtd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  mtd_sts_t sts,
  output mtd_cmd_t cmd
);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   step_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // count divider steps; clear while decoding
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (state == S_DECODE) begin
      step_cnt <= '0;
    end else if (state == S_DIVIDE) begin
      step_cnt <= step_cnt + CNT_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: state_next = sts.need_div ? S_DIVIDE : S_WRITE;
      S_DIVIDE: if (step_cnt == CNT_W'(DIV_STEPS - 1)) state_next = S_WRITE;
      S_WRITE:  if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // hold ready low during reset so no word is taken before the sequencer runs
  always_comb begin
    in_ready     = (state == S_IDLE) && !rst;
    cmd.capture  = (state == S_IDLE) && in_valid && !rst;
    cmd.decode   = (state == S_DECODE);
    cmd.div_step = (state == S_DIVIDE);
    cmd.commit   = (state == S_WRITE) && sts.out_free;
  end

endmodule

/* rtl/mtd_datapath.sv */
// Datapath of the motor telemetry decoder: frame classification, restoring
// divider, per-motor store and output register. Depends on mtd_pkg.
module mtd_datapath
  import mtd_pkg::*;
#(
  parameter int MOTOR_COUNT = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mtd_cmd_t             cmd,
  output mtd_sts_t             sts,
  input  logic [MOTOR_W-1:0]   in_motor,
  input  logic [FRAME_W-1:0]   in_frame,
  input  logic                 in_pending,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VALUE_W-1:0]   out_value,
  output logic [KIND_W-1:0]    out_kind,
  output logic                 out_frame_valid,
  output logic                 out_erpm_active,
  output logic [TEMP_W-1:0]    out_peak
);

  // captured word
  logic [MOTOR_W-1:0]    motor_q;
  logic [FRAME_W-1:0]    frame_q;
  logic                  pending_q;

  // decode result
  logic [KIND_W-1:0]     res_kind;
  logic                  res_valid;
  logic [TEMP_W-1:0]     res_byte;
  logic                  res_from_div;

  // divider
  logic [PERIOD_W-1:0]   rem_q;
  logic [VALUE_W-1:0]    quo_q;
  logic [PERIOD_W-1:0]   divisor_q;

  // per-motor store
  logic [KIND_COUNT-1:0] seen_mem [MOTOR_COUNT];
  logic [TEMP_W-1:0]     peak_mem [MOTOR_COUNT];

  logic                  in_range;
  logic [KIND_COUNT-1:0] seen_rd;
  logic [TEMP_W-1:0]     peak_rd;

  logic [3:0]            nib;
  logic [MANT_W-1:0]     mant;
  logic [PERIOD_W-1:0]   period;
  logic                  ext_ok;
  logic                  ext_frame;
  logic [KIND_W-1:0]     dec_kind;
  logic                  dec_valid;
  logic [TEMP_W-1:0]     dec_byte;
  logic                  dec_div;

  logic [PERIOD_W:0]     trial;
  logic                  trial_ge;

  logic [VALUE_W-1:0]    val_final;
  logic [KIND_COUNT-1:0] seen_new;
  logic                  temp_raise;
  logic [TEMP_W-1:0]     peak_new;
  logic                  store_wr;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      motor_q   <= in_motor;
      frame_q   <= in_frame;
      pending_q <= in_pending;
    end
  end

  always_comb begin
    in_range = 1'b0;
    seen_rd  = '0;
    peak_rd  = '0;
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      if (int'(motor_q) == m) begin
        in_range = 1'b1;
        seen_rd  = seen_mem[m];
        peak_rd  = peak_mem[m];
      end
    end
  end

  // classify the frame against what this motor has shown so far
  always_comb begin
    nib       = frame_q[FRAME_W-1:FRAME_W-4];
    mant      = frame_q[MANT_W-1:0];
    period    = PERIOD_W'(mant) << frame_q[FRAME_W-1:MANT_W];
    ext_ok    = |seen_rd[KIND_COUNT-1:1];
    ext_frame = (nib != 4'd0) && !nib[0];
    dec_kind  = KIND_ERPM;
    dec_byte  = '0;
    dec_valid = 1'b0;
    dec_div   = 1'b0;
    priority if (ext_ok && ext_frame) begin
      dec_kind  = nib[3:1];
      dec_byte  = frame_q[TEMP_W-1:0];
      dec_valid = 1'b1;
    end else if (!ext_ok && pending_q) begin
      if (frame_q == FRAME_STATE_ENABLE) begin
        dec_kind  = KIND_STATE;
        dec_valid = 1'b1;
      end
    end else if (frame_q == FRAME_ZERO_RPM) begin
      dec_valid = 1'b1;
    end else if (mant != '0) begin
      dec_valid = 1'b1;
      dec_div   = 1'b1;
    end else begin
      // zero period: drop the word as invalid
      dec_valid = 1'b0;
    end
  end

  assign sts.need_div = dec_div;

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      res_kind     <= dec_kind;
      res_valid    <= dec_valid;
      res_byte     <= dec_byte;
      res_from_div <= dec_div;
    end
  end

  // restoring division, one quotient bit per step; numerator rounds by period/2
  assign trial    = {rem_q, quo_q[VALUE_W-1]};
  assign trial_ge = trial >= {1'b0, divisor_q};

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      rem_q     <= '0;
      quo_q     <= ERPM_NUMERATOR + VALUE_W'(period >> 1);
      divisor_q <= period;
    end else if (cmd.div_step) begin
      rem_q <= trial_ge ? PERIOD_W'(trial - {1'b0, divisor_q}) : trial[PERIOD_W-1:0];
      quo_q <= {quo_q[VALUE_W-2:0], trial_ge};
    end
  end

  always_comb begin
    val_final  = res_from_div ? quo_q : VALUE_W'(res_byte);
    seen_new   = seen_rd;
    if (res_valid) seen_new = seen_rd | (KIND_COUNT'(1) << res_kind);
    temp_raise = res_valid && (res_kind == KIND_TEMP) && (res_byte > peak_rd);
    peak_new   = temp_raise ? res_byte : peak_rd;
    store_wr   = cmd.commit && in_range && res_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        seen_mem[m] <= '0;
        peak_mem[m] <= '0;
      end
    end else if (store_wr) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        if (int'(motor_q) == m) begin
          seen_mem[m] <= seen_new;
          peak_mem[m] <= peak_new;
        end
      end
    end
  end

  // output register
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_value       <= res_valid ? val_final : '0;
      out_kind        <= res_valid ? res_kind : KIND_ERPM;
      out_frame_valid <= res_valid;
      out_erpm_active <= in_range && seen_new[KIND_ERPM];
      out_peak        <= in_range ? peak_new : '0;
    end
  end

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result written over a word still waiting");

  a_commit_shows_word: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("written result not presented");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_frame_valid) |-> (out_value == '0 && out_kind == KIND_ERPM))
    else $error("rejected frame carries data");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem_q < divisor_q))
    else $error("divider remainder out of range");

endmodule

/* rtl/motor_telemetry_decoder.sv */
// Top level of the motor telemetry decoder: stream ports, sequencer and datapath.
// Depends on mtd_pkg, mtd_ctrl and mtd_datapath.
//
//   channel  dir  tdata (low bit up)                       tuser (low bit up)
//   s_axis   in   raw_frame[11:0], zero pad to 16          motor_index[2:0], ext_enable_pending[3]
//   m_axis   out  decoded_value[19:0], erpm_active[20],    telemetry_kind[2:0], frame_valid[3]
//                 peak_temperature[28:21], zero pad to 32
//
// An eRPM frame that needs division runs from accept to the next accept through
// capture, decode, 20 steps of the restoring divider, and a write of the store and
// the output register. Every other frame skips the divider steps.
// The per-motor seen bits and peak temperatures clear synchronously under rst.
// A result waits in the output register while the next word is accepted and
// decoded; the write step holds until that register is free.
module motor_telemetry_decoder
  import mtd_pkg::*;
#(
  parameter int MOTOR_COUNT = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // raw_frame[11:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,   // motor_index[2:0], ext_enable_pending[3]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // decoded_value, erpm_active, peak_temperature
  output logic [M_TUSER_W-1:0] m_axis_tuser    // telemetry_kind[2:0], frame_valid[3]
);

  mtd_cmd_t             cmd;
  mtd_sts_t             sts;
  logic [VALUE_W-1:0]   decoded_value;
  logic [KIND_W-1:0]    telemetry_kind;
  logic                 frame_valid;
  logic                 erpm_active;
  logic [TEMP_W-1:0]    peak_temperature;

  mtd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtd_datapath #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_motor        (s_axis_tuser[MOTOR_W-1:0]),
    .in_frame        (s_axis_tdata[FRAME_W-1:0]),
    .in_pending      (s_axis_tuser[MOTOR_W]),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_value       (decoded_value),
    .out_kind        (telemetry_kind),
    .out_frame_valid (frame_valid),
    .out_erpm_active (erpm_active),
    .out_peak        (peak_temperature)
  );

  // pack the result word; pad the top bits with zeros
  assign m_axis_tdata = M_TDATA_W'({peak_temperature, erpm_active, decoded_value});
  assign m_axis_tuser = {frame_valid, telemetry_kind};

endmodule
